[rtl/pts_pkg.sv]
`timescale 1ns / 1ps
// Package for the periodic task slot scheduler: request kinds, controller
// states, the stored slot word and the result layout. No dependencies.
package pts_pkg;

  // Default number of task slots.
  localparam int MAX_TASKS = 8;

  // A dispatch pass emits at most this many results.
  localparam int RESULT_CAP = 8;
  localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

  // Request kinds carried on the input tuser.
  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_CREATE   = 3'd1,
    KIND_DELETE   = 3'd2,
    KIND_SUSPEND  = 3'd3,
    KIND_RESUME   = 3'd4,
    KIND_DISPATCH = 3'd5,
    KIND_QUERY    = 3'd6
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FAIL
  } state_e;

  // Per-slot word held in the slot memory.
  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  handle;
  } slot_t;

  // One result as held in the output register.
  typedef struct packed {
    logic       found;
    logic [3:0] slot;
    logic [7:0] handle;
    logic       resumed;
    logic       last;
  } result_t;

endpackage

[rtl/periodic_task_slot_scheduler_top.sv]
`timescale 1ns / 1ps
// Top level of the periodic task slot scheduler: a slot memory walked by a
// small sequencer, with flag bits in flip-flops. Depends on pts_pkg.
//
// Usage: requests arrive on the s_axis channel, the request kind on tuser and
// the operands on tdata. Results leave on the m_axis channel through a single
// output register; tlast marks the final result of a request, and a request
// that causes no result (tick, delete, suspend, resume) shows nothing.
// Delete, suspend, resume and query complete in the cycle they are accepted;
// a query result is visible in the cycle after. Tick, create and dispatch
// walk the slot memory one slot a cycle through its read port while the
// receiver keeps up, holding the sequencer until the walk ends (a create that
// finds no free slot then passes the fail state; a create or dispatch stops
// early at its final result). A request is taken only while the sequencer is
// idle and the output register is free or being emptied, so no new request is
// taken during a walk. When the receiver stalls, the walk pauses on the next
// slot with a result until the waiting one is taken.
// Reset clears all occupied, resumed and run flags at once; the slot memory
// needs no clearing, as its words are read only for occupied slots.
module periodic_task_slot_scheduler_top #(
  parameter int MaxTasks = pts_pkg::MAX_TASKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: slot_index[2:0], task_handle[10:3], initial_delay[26:11],
  // period[42:27], zero padding[47:43].
  input  logic [47:0] s_axis_tdata,
  // tuser: kind[2:0].
  input  logic [2:0]  s_axis_tuser,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_slot[3:0], run_handle[11:4], task_resumed[12],
  // zero padding[15:13].
  output logic [15:0] m_axis_tdata,
  // tuser: found[0].
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW = $clog2(MaxTasks + 1);
  localparam int ResW = pts_pkg::RES_CNT_W;

  // Request fields.
  logic [2:0]      in_slot;
  logic [7:0]      in_handle;
  logic [15:0]     in_delay;
  logic [15:0]     in_period;
  pts_pkg::kind_e  in_kind;
  logic            in_range;
  logic [IdxW-1:0] in_idx;

  assign in_slot   = s_axis_tdata[2:0];
  assign in_handle = s_axis_tdata[10:3];
  assign in_delay  = s_axis_tdata[26:11];
  assign in_period = s_axis_tdata[42:27];
  assign in_kind   = pts_pkg::kind_e'(s_axis_tuser);
  assign in_range  = int'(in_slot) < MaxTasks;
  assign in_idx    = IdxW'(in_slot);

  // Control and flag registers.
  pts_pkg::state_e     state_q, state_d;
  pts_pkg::kind_e      kind_q, kind_d;
  logic [MaxTasks-1:0] used_q, used_d;
  logic [MaxTasks-1:0] resumed_q, resumed_d;
  logic [MaxTasks-1:0] ready_q, ready_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic                p_vld_q, p_vld_d;
  logic [IdxW-1:0]     p_idx_q, p_idx_d;
  logic [ResW-1:0]     n_q, n_d;
  logic                out_vld_q;

  // Operands of a create request, held for the walk.
  logic [7:0]  cr_handle_q, cr_handle_d;
  logic [15:0] cr_delay_q, cr_delay_d;
  logic [15:0] cr_period_q, cr_period_d;

  // Result register.
  pts_pkg::result_t out_q, res;
  logic             out_load;
  logic             out_free;

  // Slot memory and its ports.
  pts_pkg::slot_t  mem_q [MaxTasks];
  pts_pkg::slot_t  mem_rd_q;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  pts_pkg::slot_t  mem_wdata;

  // Walk status of the slot in the processing stage.
  logic                accept;
  logic                p_used;
  logic                p_elig;
  logic [MaxTasks-1:0] elig;
  logic [MaxTasks-1:0] above;
  logic                disp_last;
  logic                p_emit;
  logic                stall;
  logic                p_stop;
  logic                scan_dry;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == pts_pkg::ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign elig   = ready_q & resumed_q;
  assign p_used = used_q[p_idx_q];
  assign p_elig = elig[p_idx_q];

  // Slots after the one being processed, to find the final dispatch result.
  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      above[i] = i > int'(p_idx_q);
    end
  end

  assign disp_last = (n_q == ResW'(pts_pkg::RESULT_CAP - 1)) || !(|(elig & above));

  assign p_emit = p_vld_q &&
                  (((kind_q == pts_pkg::KIND_CREATE) && !p_used) ||
                   ((kind_q == pts_pkg::KIND_DISPATCH) && p_elig));
  assign stall  = p_emit && !out_free;
  assign p_stop = p_emit && !stall &&
                  ((kind_q == pts_pkg::KIND_CREATE) || disp_last);
  assign scan_dry = (ptr_q == CntW'(MaxTasks)) && !p_vld_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (accept && ((in_kind == pts_pkg::KIND_TICK) ||
                       (in_kind == pts_pkg::KIND_CREATE) ||
                       (in_kind == pts_pkg::KIND_DISPATCH))) begin
          state_d = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (p_stop) begin
          state_d = pts_pkg::ST_IDLE;
        end else if (scan_dry) begin
          state_d = (kind_q == pts_pkg::KIND_CREATE) ? pts_pkg::ST_FAIL
                                                      : pts_pkg::ST_IDLE;
        end
      end
      pts_pkg::ST_FAIL: begin
        if (out_free) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  // Datapath, flag updates and memory accesses.
  always_comb begin
    kind_d      = kind_q;
    used_d      = used_q;
    resumed_d   = resumed_q;
    ready_d     = ready_q;
    ptr_d       = ptr_q;
    p_vld_d     = p_vld_q;
    p_idx_d     = p_idx_q;
    n_d         = n_q;
    cr_handle_d = cr_handle_q;
    cr_delay_d  = cr_delay_q;
    cr_period_d = cr_period_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[IdxW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = p_idx_q;
    mem_wdata   = mem_rd_q;
    out_load    = 1'b0;
    res         = '0;

    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d      = in_kind;
          ptr_d       = '0;
          p_vld_d     = 1'b0;
          n_d         = '0;
          cr_handle_d = in_handle;
          cr_delay_d  = in_delay;
          cr_period_d = in_period;
          case (in_kind)
            pts_pkg::KIND_DELETE: begin
              if (in_range) begin
                used_d[in_idx]    = 1'b0;
                resumed_d[in_idx] = 1'b0;
                ready_d[in_idx]   = 1'b0;
              end
            end
            pts_pkg::KIND_SUSPEND: begin
              if (in_range) begin
                resumed_d[in_idx] = 1'b0;
              end
            end
            pts_pkg::KIND_RESUME: begin
              if (in_range) begin
                resumed_d[in_idx] = 1'b1;
              end
            end
            pts_pkg::KIND_QUERY: begin
              out_load    = 1'b1;
              res.slot    = 4'(in_slot);
              res.resumed = in_range && resumed_q[in_idx];
              res.last    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      pts_pkg::ST_SCAN: begin
        // Issue the read of the next slot unless the walk holds or ends.
        if (!stall && !p_stop) begin
          if (ptr_q < CntW'(MaxTasks)) begin
            mem_re  = 1'b1;
            p_vld_d = 1'b1;
            p_idx_d = ptr_q[IdxW-1:0];
            ptr_d   = ptr_q + CntW'(1);
          end else begin
            p_vld_d = 1'b0;
          end
        end else if (p_stop) begin
          p_vld_d = 1'b0;
        end

        // Modify and write back the slot held in the read register.
        if (p_vld_q && !stall) begin
          case (kind_q)
            pts_pkg::KIND_TICK: begin
              if (p_used) begin
                mem_we = 1'b1;
                if (mem_rd_q.delay == 16'd0) begin
                  ready_d[p_idx_q] = 1'b1;
                  mem_wdata.delay  = mem_rd_q.period - 16'd1;
                end else begin
                  mem_wdata.delay  = mem_rd_q.delay - 16'd1;
                end
              end
            end
            pts_pkg::KIND_CREATE: begin
              if (!p_used) begin
                used_d[p_idx_q]    = 1'b1;
                resumed_d[p_idx_q] = 1'b1;
                ready_d[p_idx_q]   = 1'b0;
                mem_we             = 1'b1;
                mem_wdata.delay    = cr_delay_q;
                mem_wdata.period   = cr_period_q;
                mem_wdata.handle   = cr_handle_q;
                out_load           = 1'b1;
                res.found          = 1'b1;
                res.slot           = 4'(p_idx_q);
                res.handle         = cr_handle_q;
                res.resumed        = 1'b1;
                res.last           = 1'b1;
              end
            end
            pts_pkg::KIND_DISPATCH: begin
              if (p_elig) begin
                ready_d[p_idx_q] = 1'b0;
                n_d              = n_q + ResW'(1);
                out_load         = 1'b1;
                res.found        = 1'b1;
                res.slot         = 4'(p_idx_q);
                res.handle       = mem_rd_q.handle;
                res.resumed      = 1'b1;
                res.last         = disp_last;
                // A one-shot task leaves its slot once it has been emitted.
                if (mem_rd_q.period == 16'd0) begin
                  used_d[p_idx_q]    = 1'b0;
                  resumed_d[p_idx_q] = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      pts_pkg::ST_FAIL: begin
        // No free slot: report the slot count in place of an index.
        if (out_free) begin
          out_load = 1'b1;
          res.slot = 4'(MaxTasks);
          res.last = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // Slot memory: the write goes to the processed slot, the read to the next
  // one, so the two never address the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pts_pkg::ST_IDLE;
      kind_q    <= pts_pkg::KIND_TICK;
      used_q    <= '0;
      resumed_q <= '0;
      ready_q   <= '0;
      ptr_q     <= '0;
      p_vld_q   <= 1'b0;
      n_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      used_q    <= used_d;
      resumed_q <= resumed_d;
      ready_q   <= ready_d;
      ptr_q     <= ptr_d;
      p_vld_q   <= p_vld_d;
      n_q       <= n_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    cr_handle_q <= cr_handle_d;
    cr_delay_q  <= cr_delay_d;
    cr_period_q <= cr_period_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  // Result channel.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.resumed, out_q.handle, out_q.slot};
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tlast  = out_q.last;

endmodule

[test/tb_periodic_task_slot_scheduler_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the periodic task slot scheduler: a directed
// run, then random requests checked against a slot table tracker.
// Depends on pts_pkg and periodic_task_slot_scheduler_top.
module tb_periodic_task_slot_scheduler_top;

  localparam int          NumSlots    = pts_pkg::MAX_TASKS;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;
  localparam int          RandomReqs  = 200;
  localparam int          CalmFrom    = 160;
  localparam int          IdleLimit   = 1000;
  localparam int          DrainCycles = 2 * (NumSlots + 2);

  // Tracks the slot table and holds the results each request should cause.
  class task_table_tracker;
    bit               used[NumSlots];
    bit               resumed[NumSlots];
    bit               ready[NumSlots];
    logic [15:0]      delay[NumSlots];
    logic [15:0]      period[NumSlots];
    logic [7:0]       handle[NumSlots];
    pts_pkg::result_t due_results_q[$];
    int unsigned      fault_cnt;

    function void clear_slot(int s);
      used[s]    = 1'b0;
      resumed[s] = 1'b0;
      ready[s]   = 1'b0;
      delay[s]   = '0;
      period[s]  = '0;
      handle[s]  = '0;
    endfunction

    function void report(string msg);
      fault_cnt++;
      if (fault_cnt <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    // Applies one accepted request and queues the results it causes.
    function void note_request(logic [2:0] kind, logic [2:0] idx, logic [7:0] hdl,
                               logic [15:0] dly, logic [15:0] per);
      pts_pkg::result_t r;
      int               s;
      int               emit_total;
      int               emitted;
      r = '0;
      emit_total = 0;
      emitted = 0;
      case (kind)
        pts_pkg::KIND_TICK: begin
          for (s = 0; s < NumSlots; s++) begin
            if (used[s]) begin
              if (delay[s] == 16'd0) begin
                ready[s] = 1'b1;
                delay[s] = period[s];
              end
              delay[s] = delay[s] - 16'd1;
            end
          end
        end
        pts_pkg::KIND_CREATE: begin
          for (s = 0; s < NumSlots; s++) if (!used[s]) break;
          if (s < NumSlots) begin
            used[s]    = 1'b1;
            resumed[s] = 1'b1;
            ready[s]   = 1'b0;
            delay[s]   = dly;
            period[s]  = per;
            handle[s]  = hdl;
            r.found    = 1'b1;
            r.slot     = 4'(s);
            r.handle   = hdl;
            r.resumed  = 1'b1;
          end else begin
            r.slot = 4'(NumSlots);
          end
          r.last = 1'b1;
          due_results_q.push_back(r);
        end
        pts_pkg::KIND_DELETE:  clear_slot(idx);
        pts_pkg::KIND_SUSPEND: resumed[idx] = 1'b0;
        pts_pkg::KIND_RESUME:  resumed[idx] = 1'b1;
        pts_pkg::KIND_DISPATCH: begin
          // Count first so that the final result of the pass can be marked.
          for (s = 0; s < NumSlots; s++)
            if (ready[s] && resumed[s] && emit_total < pts_pkg::RESULT_CAP) emit_total++;
          for (s = 0; s < NumSlots && emitted < emit_total; s++) begin
            if (ready[s] && resumed[s]) begin
              ready[s]  = 1'b0;
              r.found   = 1'b1;
              r.slot    = 4'(s);
              r.handle  = handle[s];
              r.resumed = 1'b1;
              r.last    = (emitted == emit_total - 1);
              due_results_q.push_back(r);
              emitted++;
              if (period[s] == 16'd0) clear_slot(s);
            end
          end
        end
        pts_pkg::KIND_QUERY: begin
          r.slot    = {1'b0, idx};
          r.resumed = resumed[idx];
          r.last    = 1'b1;
          due_results_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result with the oldest outstanding one.
    function void check_result(pts_pkg::result_t got);
      pts_pkg::result_t want;
      if (due_results_q.size() == 0) begin
        report($sformatf("unexpected result: found %0d slot %0d handle %0d resumed %0d last %0d",
                         got.found, got.slot, got.handle, got.resumed, got.last));
        return;
      end
      want = due_results_q.pop_front();
      if (got.found !== want.found || got.slot !== want.slot ||
          got.handle !== want.handle || got.resumed !== want.resumed ||
          got.last !== want.last)
        report($sformatf({"mismatch: expected found %0d slot %0d handle %0d resumed %0d ",
                          "last %0d, got found %0d slot %0d handle %0d resumed %0d last %0d"},
                         want.found, want.slot, want.handle, want.resumed, want.last,
                         got.found, got.slot, got.handle, got.resumed, got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  task_table_tracker table_trk;
  bit                calm;
  int                idle_cycles = 0;

  periodic_task_slot_scheduler_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result receiver: stalls in random bursts until the calm final stretch.
  // A new burst only starts while tready is high.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && stall_left == 0 && m_axis_tready && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    pts_pkg::result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found   = m_axis_tuser;
        got.slot    = m_axis_tdata[3:0];
        got.handle  = m_axis_tdata[11:4];
        got.resumed = m_axis_tdata[12];
        got.last    = m_axis_tlast;
        table_trk.check_result(got);
      end
      if (s_axis_tvalid && s_axis_tready)
        table_trk.note_request(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[10:3],
                               s_axis_tdata[26:11], s_axis_tdata[42:27]);
    end
  end

  // Watchdog on cycles in which neither side moves a request or a result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("periodic_task_slot_scheduler_top regression: fail");
      $finish;
    end
  end

  // Offers one request, with an optional random gap before it.
  task automatic send_request(logic [2:0] kind, logic [2:0] idx, logic [7:0] hdl,
                              logic [15:0] dly, logic [15:0] per);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, per, dly, hdl, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Random request, weighted towards ticks and dispatch passes so that
  // periodic and one-shot tasks actually fire.
  task automatic send_random_request();
    int          pick;
    logic [2:0]  kind;
    logic [15:0] dly;
    logic [15:0] per;
    pick = $urandom_range(0, 99);
    if      (pick < 30) kind = pts_pkg::KIND_TICK;
    else if (pick < 50) kind = pts_pkg::KIND_DISPATCH;
    else if (pick < 65) kind = pts_pkg::KIND_CREATE;
    else if (pick < 73) kind = pts_pkg::KIND_DELETE;
    else if (pick < 80) kind = pts_pkg::KIND_SUSPEND;
    else if (pick < 88) kind = pts_pkg::KIND_RESUME;
    else if (pick < 98) kind = pts_pkg::KIND_QUERY;
    else                kind = KIND_UNUSED;
    if ($urandom_range(0, 4) == 0) begin
      dly = 16'($urandom);
      per = 16'($urandom);
    end else begin
      dly = 16'($urandom_range(0, 3));
      per = 16'($urandom_range(0, 5));
    end
    send_request(kind, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), dly, per);
  endtask

  // Main sequence.
  initial begin
    table_trk     = new();
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pts_pkg::KIND_TICK;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: fill the table, overflow it, fire and dispatch tasks,
    // and work suspend and resume on busy and free slots.
    send_request(pts_pkg::KIND_QUERY,    3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h00, 16'h0000, 16'h0000); // handle zero
    send_request(pts_pkg::KIND_CREATE,   3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'hA5, 16'h0000, 16'h0002);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h5A, 16'h0000, 16'h0001);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h11, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h22, 16'h0000, 16'h0003);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h33, 16'h0000, 16'hAAAA);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h44, 16'h0000, 16'h5555);
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h99, 16'h1234, 16'h4321); // table full
    send_request(pts_pkg::KIND_SUSPEND,  3'd2, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_QUERY,    3'd2, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_TICK,     3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_DISPATCH, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_RESUME,   3'd2, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_DISPATCH, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_DELETE,   3'd7, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_RESUME,   3'd7, 8'h00, 16'h0000, 16'h0000); // free slot
    send_request(pts_pkg::KIND_QUERY,    3'd7, 8'h00, 16'h0000, 16'h0000);
    send_request(KIND_UNUSED,            3'd5, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(pts_pkg::KIND_TICK,     3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_TICK,     3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_DISPATCH, 3'd0, 8'h00, 16'h0000, 16'h0000);
    send_request(pts_pkg::KIND_DISPATCH, 3'd0, 8'h00, 16'h0000, 16'h0000); // none ready
    send_request(pts_pkg::KIND_CREATE,   3'd0, 8'h77, 16'h0000, 16'h0000);

    // Random part; the last stretch runs without idling on either side.
    for (int i = 0; i < RandomReqs; i++) begin
      if (i == CalmFrom) calm = 1'b1;
      send_random_request();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow a few walks' worth of cycles for stray results.
    while (table_trk.due_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (table_trk.due_results_q.size() != 0)
      table_trk.report($sformatf("%0d results never arrived",
                                 table_trk.due_results_q.size()));

    if (table_trk.fault_cnt == 0) begin
      $display("periodic_task_slot_scheduler_top regression: pass");
    end else begin
      $display("periodic_task_slot_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
